// ----- sv/efd_pkg.sv -----
package efd_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_START  = 2'd0;
    localparam logic [1:0] REG_END    = 2'd1;
    localparam logic [1:0] REG_ESCAPE = 2'd2;

    localparam logic [7:0] START_RESET  = 8'd141;
    localparam logic [7:0] END_RESET    = 8'd216;
    localparam logic [7:0] ESCAPE_RESET = 8'd171;

    localparam logic [7:0] ESC_OR   = 8'h88;
    localparam logic [7:0] SAT_MAX  = 8'hFF;

    localparam logic [2:0] TARGET_FLAG_BIT   = 3'd4;
    localparam logic [2:0] SOURCE_FLAG_BIT   = 3'd5;
    localparam logic [2:0] RESPONSE_FLAG_BIT = 3'd0;

    // Parser phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_FLAGS    = 4'd1;
    localparam logic [3:0] PH_TARGET   = 4'd2;
    localparam logic [3:0] PH_SOURCE   = 4'd3;
    localparam logic [3:0] PH_DEVICE   = 4'd4;
    localparam logic [3:0] PH_COMMAND  = 4'd5;
    localparam logic [3:0] PH_SEQUENCE = 4'd6;
    localparam logic [3:0] PH_ERROR    = 4'd7;
    localparam logic [3:0] PH_PAYLOAD  = 4'd8;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] STAT_GOOD    = 2'd0;
    localparam logic [1:0] STAT_BAD     = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] escape_marker;
    } t_cfg;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        logic [7:0] flags_byte;
        logic [7:0] target_id;
        logic [7:0] source_id;
        logic [7:0] device_id;
        logic [7:0] command_id;
        logic [7:0] sequence_id;
        logic [7:0] error_byte;
        logic [7:0] payload_count;
        logic [1:0] frame_status;
    } t_result;

endpackage

// ----- sv/efd_cfg.sv -----
module efd_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output efd_pkg::t_cfg   o_cfg
);
    import efd_pkg::*;

    logic [7:0] r_start;
    logic [7:0] r_end;
    logic [7:0] r_escape;
    logic       w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= START_RESET;
            r_end    <= END_RESET;
            r_escape <= ESCAPE_RESET;
        end else if (w_write) begin
            case (paddr[3:2])
                REG_START:  r_start  <= pwdata[7:0];
                REG_END:    r_end    <= pwdata[7:0];
                REG_ESCAPE: r_escape <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_START:  prdata = {24'd0, r_start};
            REG_END:    prdata = {24'd0, r_end};
            REG_ESCAPE: prdata = {24'd0, r_escape};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg.start_marker  = r_start;
    assign o_cfg.end_marker    = r_end;
    assign o_cfg.escape_marker = r_escape;

endmodule

// ----- sv/efd_core.sv -----
module efd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  efd_pkg::t_cfg     i_cfg,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output efd_pkg::t_result  o_res
);
    import efd_pkg::*;

    logic [3:0] r_phase,    n_phase;
    logic       r_esc,      n_esc;
    logic [7:0] r_flags,    n_flags;
    logic [7:0] r_target,   n_target;
    logic [7:0] r_source,   n_source;
    logic [7:0] r_device,   n_device;
    logic [7:0] r_command,  n_command;
    logic [7:0] r_sequence, n_sequence;
    logic [7:0] r_error,    n_error;
    logic [7:0] r_sum,      n_sum;
    logic [7:0] r_held,     n_held;
    logic       r_held_v,   n_held_v;
    logic [7:0] r_count,    n_count;

    logic       w_is_data;
    logic [7:0] w_d;

    always_comb begin
        n_phase    = r_phase;
        n_esc      = r_esc;
        n_flags    = r_flags;
        n_target   = r_target;
        n_source   = r_source;
        n_device   = r_device;
        n_command  = r_command;
        n_sequence = r_sequence;
        n_error    = r_error;
        n_sum      = r_sum;
        n_held     = r_held;
        n_held_v   = r_held_v;
        n_count    = r_count;
        w_is_data  = 1'b0;
        w_d        = i_byte;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_fire) begin
            if (r_esc) begin
                // An escaped byte is always data, whatever its value.
                n_esc     = 1'b0;
                w_is_data = 1'b1;
                w_d       = i_byte | ESC_OR;
            end else if (i_byte == i_cfg.start_marker) begin
                n_flags    = 8'd0;
                n_target   = 8'd0;
                n_source   = 8'd0;
                n_device   = 8'd0;
                n_command  = 8'd0;
                n_sequence = 8'd0;
                n_error    = 8'd0;
                n_sum      = 8'd0;
                n_held     = 8'd0;
                n_held_v   = 1'b0;
                n_count    = 8'd0;
                n_phase    = PH_FLAGS;
            end else if (i_byte == i_cfg.end_marker) begin
                if (r_phase == PH_PAYLOAD) begin
                    o_res_valid         = 1'b1;
                    o_res.item_kind     = KIND_SUMMARY;
                    o_res.flags_byte    = r_flags;
                    o_res.target_id     = r_target;
                    o_res.source_id     = r_source;
                    o_res.device_id     = r_device;
                    o_res.command_id    = r_command;
                    o_res.sequence_id   = r_sequence;
                    o_res.error_byte    = r_error;
                    o_res.payload_count = r_count;
                    if (!r_held_v) begin
                        o_res.frame_status = STAT_MISSING;
                    end else if (r_held == ~r_sum) begin
                        o_res.frame_status = STAT_GOOD;
                    end else begin
                        o_res.frame_status = STAT_BAD;
                    end
                end
                n_phase = PH_IDLE;
            end else if (i_byte == i_cfg.escape_marker) begin
                n_esc = 1'b1;
            end else begin
                w_is_data = 1'b1;
            end
        end

        if (w_is_data) begin
            case (r_phase)
                PH_IDLE: ;
                PH_FLAGS: begin
                    n_flags = w_d;
                    n_sum   = r_sum + w_d;
                    if (w_d[TARGET_FLAG_BIT]) begin
                        n_phase = PH_TARGET;
                    end else if (w_d[SOURCE_FLAG_BIT]) begin
                        n_phase = PH_SOURCE;
                    end else begin
                        n_phase = PH_DEVICE;
                    end
                end
                PH_TARGET: begin
                    n_target = w_d;
                    n_sum    = r_sum + w_d;
                    n_phase  = r_flags[SOURCE_FLAG_BIT] ? PH_SOURCE : PH_DEVICE;
                end
                PH_SOURCE: begin
                    n_source = w_d;
                    n_sum    = r_sum + w_d;
                    n_phase  = PH_DEVICE;
                end
                PH_DEVICE: begin
                    n_device = w_d;
                    n_sum    = r_sum + w_d;
                    n_phase  = PH_COMMAND;
                end
                PH_COMMAND: begin
                    n_command = w_d;
                    n_sum     = r_sum + w_d;
                    n_phase   = PH_SEQUENCE;
                end
                PH_SEQUENCE: begin
                    n_sequence = w_d;
                    n_sum      = r_sum + w_d;
                    n_phase    = r_flags[RESPONSE_FLAG_BIT] ? PH_ERROR : PH_PAYLOAD;
                end
                PH_ERROR: begin
                    n_error = w_d;
                    n_sum   = r_sum + w_d;
                    n_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    // The held byte is released only once a later byte shows
                    // that it was not the checksum.
                    if (r_held_v) begin
                        o_res_valid        = 1'b1;
                        o_res.item_kind    = KIND_PAYLOAD;
                        o_res.payload_byte = r_held;
                        n_sum              = r_sum + r_held;
                        if (r_count != SAT_MAX) begin
                            n_count = r_count + 8'd1;
                        end
                    end
                    n_held   = w_d;
                    n_held_v = 1'b1;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_esc      <= 1'b0;
            r_flags    <= 8'd0;
            r_target   <= 8'd0;
            r_source   <= 8'd0;
            r_device   <= 8'd0;
            r_command  <= 8'd0;
            r_sequence <= 8'd0;
            r_error    <= 8'd0;
            r_sum      <= 8'd0;
            r_held     <= 8'd0;
            r_held_v   <= 1'b0;
            r_count    <= 8'd0;
        end else begin
            r_phase    <= n_phase;
            r_esc      <= n_esc;
            r_flags    <= n_flags;
            r_target   <= n_target;
            r_source   <= n_source;
            r_device   <= n_device;
            r_command  <= n_command;
            r_sequence <= n_sequence;
            r_error    <= n_error;
            r_sum      <= n_sum;
            r_held     <= n_held;
            r_held_v   <= n_held_v;
            r_count    <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_res_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_fire)
        else $error("result produced without an input byte");
    a_summary_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.item_kind == KIND_SUMMARY) |-> r_phase == PH_PAYLOAD)
        else $error("summary outside payload phase");
    a_payload_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.item_kind == KIND_PAYLOAD) |-> r_held_v)
        else $error("payload byte released with nothing held");
    a_escape_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_esc) |=> !r_esc)
        else $error("escape flag not cleared by the escaped byte");
    a_summary_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.item_kind == KIND_SUMMARY) |=> r_phase == PH_IDLE)
        else $error("parser not idle after a summary");
`endif

endmodule

// ----- sv/escaped_frame_deframer.sv -----
// A byte taken on an input transfer sits in the input register, and its result, if
// any, is then loaded into the output register, from which it is offered on the output.
// Payload bytes come out one byte late, after the next data byte.
// Throughput: one byte per cycle; a byte waits only while a result stalls in the output register.
// Reset (synchronous, active low) returns the parser to idle, empties both registers
// and restores the marker registers to 141, 216 and 171.
module escaped_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] payload_byte, [15:8] flags_byte, [23:16] target_id, [31:24] source_id,
    // [39:32] device_id, [47:40] command_id, [55:48] sequence_id, [63:56] error_byte,
    // [71:64] payload_count, [73:72] frame_status, [79:74] zero
    output logic [79:0] m_tdata,
    output logic        m_tuser    // [0] item_kind
);
    import efd_pkg::*;

    t_cfg       w_cfg;
    t_result    w_res;
    logic       w_res_valid;
    logic       w_advance;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    efd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_advance = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready  = !r_in_valid || w_advance;

    efd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_fire      (w_advance),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_byte <= s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.item_kind;
    assign m_tdata  = {6'd0, r_out.frame_status, r_out.payload_count, r_out.error_byte,
                       r_out.sequence_id, r_out.command_id, r_out.device_id,
                       r_out.source_id, r_out.target_id, r_out.flags_byte,
                       r_out.payload_byte};

endmodule

// ----- verif/efd_checker.sv -----
module efd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] rx_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] payload_byte, [15:8] flags_byte, [23:16] target_id, [31:24] source_id,
    // [39:32] device_id, [47:40] command_id, [55:48] sequence_id, [63:56] error_byte,
    // [71:64] payload_count, [73:72] frame_status, [79:74] zero
    input  logic [79:0] i_m_tdata,
    input  logic        i_m_tuser,    // [0] item_kind
    output logic [31:0] o_fail_count,
    output logic [31:0] o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import efd_pkg::*;

    t_cfg       markers;
    logic [3:0] rx_phase;
    logic       esc_armed;
    logic [7:0] hdr_flags;
    logic [7:0] hdr_target;
    logic [7:0] hdr_source;
    logic [7:0] hdr_device;
    logic [7:0] hdr_command;
    logic [7:0] hdr_sequence;
    logic [7:0] hdr_error;
    logic [7:0] frame_sum;
    logic [7:0] held_data;
    logic       held_ok;
    logic [7:0] data_count;
    t_result    deframed_q[$];
    int         fails = 0;

    function automatic logic [7:0] field_of(input t_result r, input int k);
        case (k)
            0:       field_of = {7'd0, r.item_kind};
            1:       field_of = r.payload_byte;
            2:       field_of = r.flags_byte;
            3:       field_of = r.target_id;
            4:       field_of = r.source_id;
            5:       field_of = r.device_id;
            6:       field_of = r.command_id;
            7:       field_of = r.sequence_id;
            8:       field_of = r.error_byte;
            9:       field_of = r.payload_count;
            10:      field_of = {6'd0, r.frame_status};
            default: field_of = '0;
        endcase
    endfunction

    function automatic string name_of(input int k);
        case (k)
            0:       name_of = "item_kind";
            1:       name_of = "payload_byte";
            2:       name_of = "flags_byte";
            3:       name_of = "target_id";
            4:       name_of = "source_id";
            5:       name_of = "device_id";
            6:       name_of = "command_id";
            7:       name_of = "sequence_id";
            8:       name_of = "error_byte";
            9:       name_of = "payload_count";
            default: name_of = "frame_status";
        endcase
    endfunction

    task automatic open_frame();
        hdr_flags    = '0;
        hdr_target   = '0;
        hdr_source   = '0;
        hdr_device   = '0;
        hdr_command  = '0;
        hdr_sequence = '0;
        hdr_error    = '0;
        frame_sum    = '0;
        held_data    = '0;
        held_ok      = 1'b0;
        data_count   = '0;
        rx_phase     = PH_FLAGS;
    endtask

    task automatic accept_data(input logic [7:0] d);
        t_result r;
        logic    in_header;
        r = '0;
        in_header = (rx_phase != PH_IDLE) && (rx_phase != PH_PAYLOAD);
        case (rx_phase)
            PH_IDLE: ;
            PH_FLAGS: begin
                hdr_flags = d;
                if (d[TARGET_FLAG_BIT])
                    rx_phase = PH_TARGET;
                else if (d[SOURCE_FLAG_BIT])
                    rx_phase = PH_SOURCE;
                else
                    rx_phase = PH_DEVICE;
            end
            PH_TARGET: begin
                hdr_target = d;
                rx_phase = hdr_flags[SOURCE_FLAG_BIT] ? PH_SOURCE : PH_DEVICE;
            end
            PH_SOURCE: begin
                hdr_source = d;
                rx_phase = PH_DEVICE;
            end
            PH_DEVICE: begin
                hdr_device = d;
                rx_phase = PH_COMMAND;
            end
            PH_COMMAND: begin
                hdr_command = d;
                rx_phase = PH_SEQUENCE;
            end
            PH_SEQUENCE: begin
                hdr_sequence = d;
                rx_phase = hdr_flags[RESPONSE_FLAG_BIT] ? PH_ERROR : PH_PAYLOAD;
            end
            PH_ERROR: begin
                hdr_error = d;
                rx_phase = PH_PAYLOAD;
            end
            default: begin
                // The newest byte may turn out to be the checksum, so the one before it
                // is released only now.
                if (held_ok) begin
                    r.item_kind    = KIND_PAYLOAD;
                    r.payload_byte = held_data;
                    deframed_q.push_back(r);
                    frame_sum = frame_sum + held_data;
                    if (data_count != SAT_MAX)
                        data_count = data_count + 8'd1;
                end
                held_data = d;
                held_ok   = 1'b1;
            end
        endcase
        if (in_header)
            frame_sum = frame_sum + d;
    endtask

    task automatic close_frame();
        t_result r;
        r = '0;
        if (rx_phase == PH_PAYLOAD) begin
            r.item_kind     = KIND_SUMMARY;
            r.flags_byte    = hdr_flags;
            r.target_id     = hdr_target;
            r.source_id     = hdr_source;
            r.device_id     = hdr_device;
            r.command_id    = hdr_command;
            r.sequence_id   = hdr_sequence;
            r.error_byte    = hdr_error;
            r.payload_count = data_count;
            if (!held_ok)
                r.frame_status = STAT_MISSING;
            else if (held_data == ~frame_sum)
                r.frame_status = STAT_GOOD;
            else
                r.frame_status = STAT_BAD;
            deframed_q.push_back(r);
        end
        rx_phase = PH_IDLE;
    endtask

    task automatic deframe_byte(input logic [7:0] rx);
        // An escaped byte is data whatever its value; the marker tests follow in
        // priority order start, end, escape.
        if (esc_armed) begin
            esc_armed = 1'b0;
            accept_data(rx | ESC_OR);
        end else if (rx == markers.start_marker) begin
            open_frame();
        end else if (rx == markers.end_marker) begin
            if (rx_phase != PH_IDLE)
                close_frame();
        end else if (rx == markers.escape_marker) begin
            esc_armed = 1'b1;
        end else begin
            accept_data(rx);
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.item_kind     = i_m_tuser;
        got.payload_byte  = i_m_tdata[7:0];
        got.flags_byte    = i_m_tdata[15:8];
        got.target_id     = i_m_tdata[23:16];
        got.source_id     = i_m_tdata[31:24];
        got.device_id     = i_m_tdata[39:32];
        got.command_id    = i_m_tdata[47:40];
        got.sequence_id   = i_m_tdata[55:48];
        got.error_byte    = i_m_tdata[63:56];
        got.payload_count = i_m_tdata[71:64];
        got.frame_status  = i_m_tdata[73:72];
        if (deframed_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual kind %0d data %h",
                     $time, i_m_tuser, i_m_tdata);
            fails++;
        end else begin
            want = deframed_q.pop_front();
            for (int k = 0; k < 11; k++) begin
                if (field_of(want, k) !== field_of(got, k)) begin
                    $display("%0t: %s mismatch: expected %0d, actual %0d", $time,
                             name_of(k), field_of(want, k), field_of(got, k));
                    fails++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            markers.start_marker  = START_RESET;
            markers.end_marker    = END_RESET;
            markers.escape_marker = ESCAPE_RESET;
            esc_armed = 1'b0;
            open_frame();
            rx_phase = PH_IDLE;
            deframed_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_START:  markers.start_marker  = i_pwdata[7:0];
                    REG_END:    markers.end_marker    = i_pwdata[7:0];
                    REG_ESCAPE: markers.escape_marker = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                deframe_byte(i_s_tdata);
            if (i_m_tvalid && i_m_tready)
                check_result();
        end
        o_outstanding <= deframed_q.size();
        o_fail_count  <= fails;
    end

endmodule

// ----- verif/tb_escaped_frame_deframer.sv -----
module tb_escaped_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;
    import efd_pkg::*;

    // How a generated packet ends its checksum slot
    localparam int CK_GOOD = 0;
    localparam int CK_BAD  = 1;
    localparam int CK_NONE = 2;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;         // [7:0] payload_byte ... [73:72] frame_status, see block
    logic        m_tuser;         // [0] item_kind
    logic [31:0] fail_count;
    logic [31:0] outstanding;

    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    logic        hold_req     = 1'b0;
    logic        hold_taken   = 1'b0;
    int          hold_left    = 0;
    int          rx_sent      = 0;
    logic [7:0]  cur_start    = START_RESET;
    logic [7:0]  cur_end      = END_RESET;
    logic [7:0]  cur_escape   = ESCAPE_RESET;

    escaped_frame_deframer DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    efd_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off that backs the block up.
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= 400;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        #400_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic put_rx_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        rx_sent++;
    endtask

    // A data byte that clashes with a marker can only travel escaped, which needs both
    // bits of the escape mask set; others are nudged to a value that can travel.
    function automatic logic [7:0] legal_byte(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        while ((v == cur_start || v == cur_end || v == cur_escape) &&
               ((v & ESC_OR) != ESC_OR))
            v = v + 8'd1;
        return v;
    endfunction

    task automatic put_data_byte(input logic [7:0] b);
        logic       clash;
        logic [7:0] mask;
        clash = (b == cur_start) || (b == cur_end) || (b == cur_escape);
        mask  = 8'($urandom);
        if (clash || ((b & ESC_OR) == ESC_OR && $urandom_range(7) == 0)) begin
            put_rx_byte(cur_escape);
            put_rx_byte(b & ~(ESC_OR & mask));
        end else begin
            put_rx_byte(b);
        end
    endtask

    task automatic send_packet(input logic [7:0] flg_in, input int plen, input int ck_mode,
                               input int cut_at, input logic cut_end);
        logic [7:0] body[$];
        logic [7:0] flg;
        logic [7:0] sum;
        int         n;
        flg = legal_byte(flg_in);
        body.push_back(flg);
        if (flg[TARGET_FLAG_BIT])
            body.push_back(legal_byte(8'($urandom)));
        if (flg[SOURCE_FLAG_BIT])
            body.push_back(legal_byte(8'($urandom)));
        repeat (3)
            body.push_back(legal_byte(8'($urandom)));
        if (flg[RESPONSE_FLAG_BIT])
            body.push_back(legal_byte(8'($urandom)));
        repeat (plen)
            body.push_back(legal_byte(8'($urandom)));
        sum = '0;
        foreach (body[j])
            sum = sum + body[j];
        if (ck_mode == CK_GOOD)
            body.push_back(legal_byte(~sum));
        else if (ck_mode == CK_BAD)
            body.push_back(legal_byte(~sum ^ 8'($urandom_range(1, 255))));
        put_rx_byte(cur_start);
        n = (cut_at >= 0 && cut_at < body.size()) ? cut_at : body.size();
        for (int j = 0; j < n; j++)
            put_data_byte(body[j]);
        if (cut_at >= 0)
            put_rx_byte(cut_end ? cur_end : cur_start);
        else
            put_rx_byte(cur_end);
    endtask

    task automatic run_traffic(input int upto);
        int pick;
        int plen;
        int ck;
        int burst;
        while (rx_sent < upto) begin
            pick = $urandom_range(99);
            plen = ($urandom_range(99) == 0) ? $urandom_range(256, 262) : $urandom_range(0, 10);
            ck   = $urandom_range(9);
            if (pick < 70) begin
                send_packet(8'($urandom), plen,
                            (ck < 8) ? CK_GOOD : ((ck == 8) ? CK_BAD : CK_NONE), -1, 1'b0);
            end else if (pick < 85) begin
                send_packet(8'($urandom), plen, CK_GOOD, $urandom_range(0, 8),
                            1'($urandom_range(1)));
            end else begin
                burst = $urandom_range(1, 8);
                repeat (burst)
                    put_rx_byte(8'($urandom));
            end
        end
    endtask

    // Stop offering bytes and let every due result drain before the block is touched.
    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (4) @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START:  cur_start  = val;
            REG_END:    cur_end    = val;
            REG_ESCAPE: cur_escape = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_markers(input logic [7:0] st, input logic [7:0] en,
                                 input logic [7:0] es);
        write_reg(REG_START, st);
        write_reg(REG_END, en);
        write_reg(REG_ESCAPE, es);
    endtask

    task automatic set_idling(input int tx, input int rx);
        tx_idle_pct = tx;
        rx_stall_pct <= rx;
    endtask

    initial begin
        logic [7:0] m0;
        logic [7:0] m1;
        logic [7:0] m2;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle line: a stray end marker, then an escaped start value, both ignored.
        put_rx_byte(cur_end);
        put_rx_byte(cur_escape);
        put_rx_byte(cur_start);
        // Every optional header byte present; escaped values equal to each marker.
        put_rx_byte(cur_start);
        put_rx_byte(8'h31);
        put_rx_byte(cur_escape);
        put_rx_byte(8'h05);
        put_rx_byte(8'hFF);
        put_rx_byte(8'h00);
        put_rx_byte(cur_escape);
        put_rx_byte(8'h50);
        put_rx_byte(8'h07);
        put_rx_byte(cur_escape);
        put_rx_byte(8'h23);
        put_rx_byte(8'h5A);
        put_rx_byte(8'h11);
        put_rx_byte(cur_end);
        // No payload or checksum byte before the end marker, then an end marker inside the header.
        send_packet(8'h00, 0, CK_NONE, -1, 1'b0);
        send_packet(8'h10, 0, CK_GOOD, 1, 1'b1);
        run_traffic(350);

        settle();
        do begin
            m0 = 8'($urandom);
            m1 = 8'($urandom);
            m2 = 8'($urandom);
        end while (m0 == m1 || m1 == m2 || m0 == m2);
        write_markers(m0, m1, m2);
        set_idling(49, 0);
        run_traffic(650);

        settle();
        write_markers(8'h00, 8'hFF, ESC_OR);
        set_idling(0, 49);
        run_traffic(950);

        // All three markers alike: the start test wins every time.
        settle();
        write_markers(8'h7E, 8'h7E, 8'h7E);
        set_idling(7, 7);
        run_traffic(1050);

        settle();
        write_markers(START_RESET, END_RESET, ESCAPE_RESET);
        hold_req <= 1'b1;
        send_packet(8'($urandom), 258, CK_GOOD, -1, 1'b0);
        run_traffic(1550);

        set_idling(0, 0);
        settle();
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
